/* rtl/obdq_pkg.sv */
package obdq_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned MaxRankDefault = 31;

  localparam int unsigned SymbolWidth = 64;
  localparam int unsigned QtyWidth = 31;
  localparam int unsigned PriceWidth = 31;
  localparam int unsigned RankWidth = 5;
  localparam int unsigned KindWidth = 3;
  localparam int unsigned EntryWidth = SymbolWidth + 1 + QtyWidth + PriceWidth;

  typedef enum logic [KindWidth-1:0] {
    KIND_ACCEPT = 3'd0,
    KIND_REJECT = 3'd1,
    KIND_BUY    = 3'd2,
    KIND_SELL   = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic store;       // write insert into table
    logic load_query;  // latch query key
    logic scan_start;  // point read address at entry 0
    logic scan_step;   // advance read pointer
    logic pass_clear;  // start a new selection pass
    logic set_side;    // latch side for next pass
    logic side_val;
    logic commit;      // record winner of finished pass
    logic rank_reset;  // rank counter to 0
  } obdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;   // address of last stored entry was issued
    logic found;       // pass found a candidate
    logic rank_done;   // rank reached K
  } obdq_sts_t;

endpackage

/* rtl/obdq_ram.sv */
module obdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/obdq_datapath.sv */
module obdq_datapath #(
  parameter int unsigned TableDepth = 256,
  parameter int unsigned MaxRank = 31
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  obdq_pkg::obdq_cmd_t                  cmd,
  output obdq_pkg::obdq_sts_t                  sts,
  input  logic [obdq_pkg::SymbolWidth-1:0]     symbol,
  input  logic                                 side,
  input  logic [obdq_pkg::QtyWidth-1:0]        quantity,
  input  logic [obdq_pkg::PriceWidth-1:0]      price,
  input  logic [obdq_pkg::RankWidth-1:0]       depth,
  input  logic                                 rd_valid,
  output logic [obdq_pkg::RankWidth-1:0]       rank,
  output logic [obdq_pkg::QtyWidth-1:0]        best_qty,
  output logic [obdq_pkg::PriceWidth-1:0]      best_price
);
  import obdq_pkg::*;

  localparam int unsigned AddrWidth = $clog2(TableDepth);
  localparam int unsigned CountWidth = $clog2(TableDepth + 1);

  logic [CountWidth-1:0]  count;
  logic [AddrWidth-1:0]   raddr;
  logic [EntryWidth-1:0]  rdata;
  logic [AddrWidth-1:0]   rd_idx;       // index of entry now on rdata
  logic [SymbolWidth-1:0] key;
  logic [RankWidth-1:0]   k_sat;
  logic                   cur_side;
  logic [RankWidth-1:0]   rank_cnt;     // rows emitted on the current side

  // previous winner: pass picks the best strictly after it in (price, index) order
  logic                   have_prev;
  logic [PriceWidth-1:0]  prev_price;
  logic [AddrWidth-1:0]   prev_idx;

  logic                   found;
  logic [PriceWidth-1:0]  cand_price;
  logic [QtyWidth-1:0]    cand_qty;
  logic [AddrWidth-1:0]   cand_idx;

  logic [SymbolWidth-1:0] e_sym;
  logic                   e_side;
  logic [QtyWidth-1:0]    e_qty;
  logic [PriceWidth-1:0]  e_price;
  logic                   after_prev;
  logic                   beats_cand;
  logic                   take;

  assign {e_sym, e_side, e_qty, e_price} = rdata;

  obdq_ram #(
    .Width(EntryWidth),
    .Depth(TableDepth)
  ) u_table (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(count[AddrWidth-1:0]),
    .wdata({symbol, side, quantity, price}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (cur_side == SIDE_BUY) begin
      after_prev = !have_prev || (e_price < prev_price) ||
                   (e_price == prev_price && rd_idx > prev_idx);
      beats_cand = !found || (e_price > cand_price);
    end else begin
      after_prev = !have_prev || (e_price > prev_price) ||
                   (e_price == prev_price && rd_idx > prev_idx);
      beats_cand = !found || (e_price < cand_price);
    end
    take = rd_valid && e_sym == key && e_side == cur_side && after_prev && beats_cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= count + 1'b1;
    end
    if (cmd.load_query) begin
      key <= symbol;
      k_sat <= (depth > RankWidth'(MaxRank)) ? RankWidth'(MaxRank) : depth;
    end
    if (cmd.set_side) begin
      cur_side <= cmd.side_val;
      have_prev <= 1'b0;
    end
    if (cmd.commit) begin
      have_prev <= 1'b1;
      prev_price <= cand_price;
      prev_idx <= cand_idx;
      best_qty <= cand_qty;
      best_price <= cand_price;
      rank <= rank_cnt + 1'b1;
    end
    if (cmd.rank_reset) begin
      rank_cnt <= '0;
    end else if (cmd.commit) begin
      rank_cnt <= rank_cnt + 1'b1;
    end
    if (cmd.scan_start) begin
      raddr <= '0;
    end else if (cmd.scan_step) begin
      raddr <= raddr + 1'b1;
    end
    rd_idx <= raddr;
    if (cmd.pass_clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
      cand_price <= e_price;
      cand_qty <= e_qty;
      cand_idx <= rd_idx;
    end
  end

  assign sts.full = (count == CountWidth'(TableDepth));
  assign sts.empty = (count == '0);
  assign sts.scan_last = (CountWidth'(raddr) + CountWidth'(1) == count);
  assign sts.found = found;
  assign sts.rank_done = (rank_cnt >= k_sat);

endmodule

/* rtl/obdq_ctrl.sv */
module obdq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [obdq_pkg::KindWidth-1:0] kind,
  output logic                          last,
  output logic                          rd_valid,
  output obdq_pkg::obdq_cmd_t           cmd,
  input  obdq_pkg::obdq_sts_t           sts
);
  import obdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIDE,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_EMIT,
    S_END
  } state_t;

  state_t state;
  logic   side_q;
  logic   drain;

  logic in_acc;
  logic out_free;
  assign in_acc = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  always_comb begin
    cmd = '0;
    cmd.side_val = side_q;
    unique case (state)
      S_IDLE: begin
        if (in_acc && cmd_in == CMD_INSERT && !sts.full) begin
          cmd.store = 1'b1;
        end
        if (in_acc && cmd_in == CMD_QUERY) begin
          cmd.load_query = 1'b1;
          cmd.set_side = 1'b1;
          cmd.side_val = SIDE_BUY;
          cmd.rank_reset = 1'b1;
        end
      end
      S_SIDE: begin
        cmd.scan_start = 1'b1;
        cmd.pass_clear = 1'b1;
        if ((sts.empty || sts.rank_done) && side_q == SIDE_BUY) begin
          cmd.set_side = 1'b1;
          cmd.side_val = SIDE_SELL;
          cmd.rank_reset = 1'b1;
        end
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_EVAL: begin
        if (sts.found && out_free) begin
          cmd.commit = 1'b1;
        end
        if (!sts.found) begin
          cmd.set_side = 1'b1;
          cmd.side_val = SIDE_SELL;
          cmd.rank_reset = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rd_valid <= 1'b0;
      side_q <= SIDE_BUY;
      drain <= 1'b0;
      kind <= KIND_END;
      last <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_valid <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd_in == CMD_INSERT) begin
              out_valid <= 1'b1;
              kind <= sts.full ? KIND_REJECT : KIND_ACCEPT;
              last <= 1'b1;
            end else begin
              side_q <= SIDE_BUY;
              state <= S_SIDE;
            end
          end
        end
        S_SIDE: begin
          if (sts.empty || sts.rank_done) begin
            if (side_q == SIDE_BUY) begin
              side_q <= SIDE_SELL;
              state <= S_SIDE;
            end else begin
              state <= S_END;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state <= S_DRAIN;
            drain <= 1'b0;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!sts.found) begin
            if (side_q == SIDE_BUY) begin
              side_q <= SIDE_SELL;
              state <= S_SIDE;
            end else begin
              state <= S_END;
            end
          end else if (out_free) begin
            out_valid <= 1'b1;
            kind <= (side_q == SIDE_BUY) ? KIND_BUY : KIND_SELL;
            last <= 1'b0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          state <= S_SIDE;
        end
        S_END: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind <= KIND_END;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/order_book_depth_query_core.sv */
// Insert: the result is registered when the insert is accepted; one insert per cycle
// when the result is taken at once.
// Query: one selection pass over the stored orders per emitted row, each pass going
// through the single table read port; a pass that finds no row ends a side; end result follows.
// Reset (rst, synchronous) empties the table; stored entries are not cleared.
module order_book_depth_query_core #(
  parameter int unsigned TABLE_DEPTH = obdq_pkg::TableDepthDefault,
  parameter int unsigned MAX_RANK = obdq_pkg::MaxRankDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [obdq_pkg::SymbolWidth-1:0]  symbol,
  input  logic                              side,
  input  logic [obdq_pkg::QtyWidth-1:0]     quantity,
  input  logic [obdq_pkg::PriceWidth-1:0]   price,
  input  logic [obdq_pkg::RankWidth-1:0]    depth,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [obdq_pkg::KindWidth-1:0]    kind,
  output logic [obdq_pkg::RankWidth-1:0]    position,
  output logic [obdq_pkg::QtyWidth-1:0]     row_quantity,
  output logic [obdq_pkg::PriceWidth-1:0]   row_price,
  output logic                              last
);
  import obdq_pkg::*;

  obdq_cmd_t ctl;
  obdq_sts_t sts;
  logic      rd_valid;
  logic [RankWidth-1:0]  rank;
  logic [QtyWidth-1:0]   best_qty;
  logic [PriceWidth-1:0] best_price;
  logic is_row;

  obdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd_in   (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind     (kind),
    .last     (last),
    .rd_valid (rd_valid),
    .cmd      (ctl),
    .sts      (sts)
  );

  obdq_datapath #(
    .TableDepth(TABLE_DEPTH),
    .MaxRank   (MAX_RANK)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl),
    .sts       (sts),
    .symbol    (symbol),
    .side      (side),
    .quantity  (quantity),
    .price     (price),
    .depth     (depth),
    .rd_valid  (rd_valid),
    .rank      (rank),
    .best_qty  (best_qty),
    .best_price(best_price)
  );

  assign is_row = (kind == KIND_BUY) || (kind == KIND_SELL);
  assign position = is_row ? rank : '0;
  assign row_quantity = is_row ? best_qty : '0;
  assign row_price = is_row ? best_price : '0;

endmodule
